### rtl/core/dlr_pkg.sv
// Shared types and constants for the DDA line rasterizer.
`timescale 1ns / 1ps
package dlr_pkg;

  localparam int unsigned COORD_W        = 6;
  localparam int unsigned COLOR_W        = 32;
  localparam int unsigned COORD_BITS_DEF = 6;
  localparam int unsigned FRAC_BITS_DEF  = 16;

  typedef struct packed {
    logic [COORD_W-1:0] x_start;
    logic [COORD_W-1:0] y_start;
    logic [COORD_W-1:0] x_end;
    logic [COORD_W-1:0] y_end;
    logic [COLOR_W-1:0] line_color;
  } dlr_cmd_t;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [COLOR_W-1:0] pixel_color;
    logic               last_pixel;
  } dlr_pix_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic div_step;
    logic walk_step;
  } dlr_ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic at_end;
  } dlr_stat_t;

endpackage

### rtl/core/dlr_ctrl.sv
// Sequencer for the DDA line rasterizer: load, slope division, pixel walk.
`timescale 1ns / 1ps
module dlr_ctrl #(
  parameter int unsigned FRAC_BITS = dlr_pkg::FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  dlr_pkg::dlr_stat_t stat_i,
  output dlr_pkg::dlr_ctl_t  ctl_o
);
  import dlr_pkg::*;

  localparam int unsigned CntW = $clog2(FRAC_BITS + 1);

  typedef enum logic [1:0] {
    StIdle,
    StDiv,
    StWalk
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ctl_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (start) begin
          ctl_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = StDiv;
        end
      end
      StDiv: begin
        ctl_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        // one quotient bit per cycle, FRAC_BITS+1 bits in all
        if (cnt_q == CntW'(FRAC_BITS)) begin
          state_d = StWalk;
        end
      end
      StWalk: begin
        ctl_o.walk_step = 1'b1;
        if (stat_i.at_end) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign busy = (state_q != StIdle);

`ifndef ASSERT_OFF
  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv && cnt_q != CntW'(FRAC_BITS)) |=> (state_q == StDiv))
    else $error("slope division ended early");
  a_walk_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StWalk && stat_i.at_end) |=> (state_q == StIdle))
    else $error("walk did not stop at the line end");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv) |-> (cnt_q <= CntW'(FRAC_BITS)))
    else $error("division counter out of range");
`endif

endmodule

### rtl/core/dlr_datapath.sv
// Datapath: endpoint ordering, serial slope divider, accumulator and pixel register.
`timescale 1ns / 1ps
module dlr_datapath #(
  parameter int unsigned COORD_BITS = dlr_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = dlr_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dlr_pkg::dlr_cmd_t  cmd_i,
  input  dlr_pkg::dlr_ctl_t  ctl_i,
  output dlr_pkg::dlr_stat_t stat_o,
  output logic               pix_valid_o,
  output dlr_pkg::dlr_pix_t  pix_o
);
  import dlr_pkg::*;

  localparam int unsigned C  = COORD_BITS;
  localparam int unsigned F  = FRAC_BITS;
  localparam int unsigned AW = C + F + 1;  // signed accumulator
  localparam int unsigned SW = F + 2;      // signed slope, magnitude up to 1.0

  // endpoint ordering
  logic [C-1:0] x0, y0, x1, y1;
  logic [C-1:0] adx, ady;
  logic         maj_y;
  logic [C-1:0] a0, b0, a1, b1;
  logic         swap;
  logic [C-1:0] m0, n0, m1, n1;
  logic [C-1:0] md, nmag;
  logic         neg;

  assign x0 = cmd_i.x_start[C-1:0];
  assign y0 = cmd_i.y_start[C-1:0];
  assign x1 = cmd_i.x_end[C-1:0];
  assign y1 = cmd_i.y_end[C-1:0];

  always_comb begin
    adx   = (x1 >= x0) ? x1 - x0 : x0 - x1;
    ady   = (y1 >= y0) ? y1 - y0 : y0 - y1;
    maj_y = (ady > adx);
    a0    = maj_y ? y0 : x0;
    b0    = maj_y ? x0 : y0;
    a1    = maj_y ? y1 : x1;
    b1    = maj_y ? x1 : y1;
    swap  = (a1 < a0);
    m0    = swap ? a1 : a0;
    n0    = swap ? b1 : b0;
    m1    = swap ? a0 : a1;
    n1    = swap ? b0 : b1;
    md    = m1 - m0;
    nmag  = (n1 >= n0) ? n1 - n0 : n0 - n1;
    neg   = (n1 < n0);
  end

  // line registers
  logic [C-1:0]       m_q, m1_q, n1_q, md_q;
  logic               neg_q, maj_y_q;
  logic [COLOR_W-1:0] color_q;
  logic [C:0]         rem_q;
  logic [F:0]         quo_q;
  logic [AW-1:0]      acc_q;

  // restoring division, one quotient bit per step
  logic         ge;
  logic [C:0]   diff;
  assign ge   = (rem_q >= {1'b0, md_q});
  assign diff = ge ? rem_q - {1'b0, md_q} : rem_q;

  // slope and walk
  logic [SW-1:0] slope;
  logic [AW-1:0] slope_ext;
  logic [C-1:0]  minor;
  logic          at_end;

  assign slope     = neg_q ? (SW'(0) - {1'b0, quo_q}) : {1'b0, quo_q};
  assign slope_ext = {{(AW - SW){slope[SW-1]}}, slope};
  // accumulator stays between the endpoints; clamp a negative value anyway
  assign minor     = acc_q[AW-1] ? '0 : acc_q[C+F-1:F];
  assign at_end    = (m_q == m1_q);
  assign stat_o.at_end = at_end;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      m_q     <= m0;
      m1_q    <= m1;
      n1_q    <= n1;
      md_q    <= md;
      neg_q   <= neg;
      maj_y_q <= maj_y;
      color_q <= cmd_i.line_color;
      rem_q   <= {1'b0, nmag};
      quo_q   <= '0;
      acc_q   <= {1'b0, n0, F'(0)};
    end else if (ctl_i.div_step) begin
      rem_q <= {diff[C-1:0], 1'b0};
      quo_q <= {quo_q[F-1:0], ge};
    end else if (ctl_i.walk_step) begin
      m_q   <= m_q + 1'b1;
      acc_q <= acc_q + slope_ext;
    end
  end

  // pixel output register
  logic [C-1:0] px_n, py_n;
  always_comb begin
    if (at_end) begin
      px_n = maj_y_q ? n1_q : m1_q;
      py_n = maj_y_q ? m1_q : n1_q;
    end else begin
      px_n = maj_y_q ? minor : m_q;
      py_n = maj_y_q ? m_q : minor;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.walk_step) begin
      pix_o.pixel_x     <= COORD_W'(px_n);
      pix_o.pixel_y     <= COORD_W'(py_n);
      pix_o.pixel_color <= color_q;
      pix_o.last_pixel  <= at_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_valid_o <= 1'b0;
    end else begin
      pix_valid_o <= ctl_i.walk_step;
    end
  end

`ifndef ASSERT_OFF
  a_major_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.walk_step && !at_end && !ctl_i.load) |=> (m_q == $past(m_q) + 1'b1))
    else $error("major coordinate did not advance");
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.div_step |-> (diff < {1'b0, md_q}) || (md_q == '0))
    else $error("divider remainder out of range");
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctl_i.load, ctl_i.div_step, ctl_i.walk_step}))
    else $error("conflicting datapath commands");
`endif

endmodule

### rtl/core/dda_line_rasterizer.sv
// DDA line rasterizer: top level joining controller and datapath.
`timescale 1ns / 1ps
// A command is taken when start is high and busy is low. The block first
// computes the slope with a bit-serial restoring divider, one quotient bit per
// cycle, then emits one pixel per cycle along the major axis, major_delta+1
// pixels with last_pixel set on the final one. busy stays high through both
// phases. Each pixel is shown on pix_o for exactly one cycle with
// pixel_valid_o high; the receiver cannot stall, so it must take every pixel.
// The last pixel leaves the output register in the cycle busy drops, and a new
// command may be taken in that same cycle.
module dda_line_rasterizer #(
  parameter int unsigned COORD_BITS = dlr_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = dlr_pkg::FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  dlr_pkg::dlr_cmd_t cmd_i,
  output logic              pixel_valid_o,
  output dlr_pkg::dlr_pix_t pix_o
);
  import dlr_pkg::*;

  dlr_ctl_t  ctl;
  dlr_stat_t stat;

  dlr_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .ctl_o  (ctl)
  );

  dlr_datapath #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_i),
    .ctl_i       (ctl),
    .stat_o      (stat),
    .pix_valid_o (pixel_valid_o),
    .pix_o       (pix_o)
  );

`ifndef ASSERT_OFF
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("transaction accepted but block not busy");
  a_pix_in_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pixel_valid_o |-> $past(busy))
    else $error("pixel emitted outside a line");
  a_pix_contig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pixel_valid_o && !pix_o.last_pixel) |=> pixel_valid_o)
    else $error("gap inside a line");
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pixel_valid_o && pix_o.last_pixel) |-> !busy)
    else $error("still busy after last pixel");
`endif

endmodule
